>>> design/bdlp_pkg.sv
// Shared types and constants for the button debouncer with long-press detection.
// No dependencies; every other design file imports this package.

package bdlp_pkg;

    // Event kinds carried in the result item
    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_LONG    = 2'd2;

    // Configuration register indexes
    localparam logic CFG_DEBOUNCE   = 1'b0;
    localparam logic CFG_LONG_PRESS = 1'b1;

    // Configuration reset values (milliseconds)
    localparam logic [15:0] DEBOUNCE_RESET   = 16'd35;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd800;

    typedef struct packed {
        logic        raw_level;
        logic [31:0] sample_time;
        logic [2:0]  action_tag;
    } in_item_t;

    typedef struct packed {
        logic       event_valid;
        logic [1:0] event_kind;
        logic [2:0] event_action;
    } out_item_t;

endpackage

>>> design/bdlp_in_stage.sv
// Input register stage: holds one accepted sample until the evaluation logic takes it.
// Depends on bdlp_pkg.

module bdlp_in_stage
    import bdlp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     hold_valid,
    input  logic     hold_take,
    output in_item_t hold_data
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t data_reg;

    assign in_ready   = !valid_reg || hold_take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (hold_take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on every input transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_data  = data_reg;

endmodule

>>> design/bdlp_core.sv
// Debounce and long-press evaluation: configuration registers, button state and
// the per-sample decision logic. Depends on bdlp_pkg.

module bdlp_core
    import bdlp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_wen,
    input  logic      cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic      step,
    input  in_item_t  item,
    output out_item_t result
);

    logic [15:0] debounce_reg;
    logic [15:0] long_press_reg;

    logic        started_reg,       started_next;
    logic        last_raw_reg,      last_raw_next;
    logic        stable_reg,        stable_next;
    logic        long_rep_reg,      long_rep_next;
    logic [31:0] change_time_reg,   change_time_next;
    logic [31:0] press_start_reg,   press_start_next;

    logic [31:0] since_change;
    logic [31:0] since_press;
    logic        settled;
    logic        long_due;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE:   debounce_reg   <= cfg_wdata;
                CFG_LONG_PRESS: long_press_reg <= cfg_wdata;
                default:        debounce_reg   <= debounce_reg;
            endcase
        end
    end

    assign since_change = item.sample_time - change_time_reg;
    assign since_press  = item.sample_time - press_start_reg;
    assign settled      = (stable_reg != last_raw_reg)
                          && (since_change >= {16'd0, debounce_reg});
    assign long_due     = (long_press_reg != 16'd0) && stable_reg && !long_rep_reg
                          && (since_press >= {16'd0, long_press_reg});

    always_comb
    begin
        started_next       = started_reg;
        last_raw_next      = last_raw_reg;
        stable_next        = stable_reg;
        long_rep_next      = long_rep_reg;
        change_time_next   = change_time_reg;
        press_start_next   = press_start_reg;
        result.event_valid  = 1'b0;
        result.event_kind   = KIND_PRESS;
        result.event_action = item.action_tag;

        priority if (!started_reg)
        begin
            // First sample only loads the state
            started_next     = 1'b1;
            last_raw_next    = item.raw_level;
            stable_next      = item.raw_level;
            long_rep_next    = 1'b0;
            change_time_next = item.sample_time;
            press_start_next = item.raw_level ? item.sample_time : 32'd0;
        end
        else if (item.raw_level != last_raw_reg)
        begin
            // Raw edge: restart settle timer
            last_raw_next    = item.raw_level;
            change_time_next = item.sample_time;
        end
        else if (settled)
        begin
            stable_next = last_raw_reg;
            if (last_raw_reg)
            begin
                long_rep_next      = 1'b0;
                press_start_next   = item.sample_time;
                result.event_valid = 1'b1;
                result.event_kind  = KIND_PRESS;
            end
            else
            begin
                press_start_next = 32'd0;
                if (!long_rep_reg)
                begin
                    result.event_valid = 1'b1;
                    result.event_kind  = KIND_RELEASE;
                end
                long_rep_next = 1'b0;
            end
        end
        else if (long_due)
        begin
            long_rep_next      = 1'b1;
            result.event_valid = 1'b1;
            result.event_kind  = KIND_LONG;
        end
        else
        begin
            started_next = started_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg     <= 1'b0;
            last_raw_reg    <= 1'b0;
            stable_reg      <= 1'b0;
            long_rep_reg    <= 1'b0;
            change_time_reg <= 32'd0;
            press_start_reg <= 32'd0;
        end
        else if (step)
        begin
            started_reg     <= started_next;
            last_raw_reg    <= last_raw_next;
            stable_reg      <= stable_next;
            long_rep_reg    <= long_rep_next;
            change_time_reg <= change_time_next;
            press_start_reg <= press_start_next;
        end
    end

endmodule

>>> design/bdlp_out_stage.sv
// Result register stage: holds one result item until the receiver takes it.
// Depends on bdlp_pkg.

module bdlp_out_stage
    import bdlp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load_valid,
    output logic      load_ready,
    input  out_item_t load_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    assign load_ready = !valid_reg || out_ready;
    assign valid_next = (load_valid && load_ready) ? 1'b1
                      : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> design/button_debounce_long_press.sv
// Top level of the button debouncer with long-press detection.
// Depends on bdlp_pkg, bdlp_in_stage, bdlp_core and bdlp_out_stage.
//
// Usage:
//   Input channel (in_valid / in_ready / in_data) carries one timestamped
//   button sample per transfer: raw level, millisecond time, action tag.
//   Output channel (out_valid / out_ready / out_data) returns exactly one
//   result per sample: event flag, event kind (press, release, long press)
//   and the copied action tag, in sample order.
//   Configuration: write cfg_wdata to register cfg_index when cfg_wen is
//   high (0 = debounce time, 1 = long-press time, both in ms). Write only
//   while no sample is in flight.
// Timing:
//   A sample goes from the input register through the decision logic into
//   the result register. Throughput is one sample per cycle while out_ready
//   stays high; the button state loop (compare of two wrapping 32-bit
//   differences and flag update) feeds the state registers straight back.
// Reset:
//   All state clears, debounce time returns to 35 ms and long-press time to
//   800 ms; the first sample after reset only loads the state.
// Stall:
//   When out_ready is low the result register holds; the input register
//   still takes one more sample, then in_ready drops until the result drains.

module button_debounce_long_press
    import bdlp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_wen,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic      hold_valid;
    logic      hold_take;
    in_item_t  hold_data;
    logic      load_ready;
    out_item_t core_result;

    // Hold the accepted sample
    bdlp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .hold_valid (hold_valid),
        .hold_take  (hold_take),
        .hold_data  (hold_data)
    );

    // Advance the button state exactly when the sample moves to the result register
    assign hold_take = hold_valid && load_ready;

    bdlp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step      (hold_take),
        .item      (hold_data),
        .result    (core_result)
    );

    bdlp_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (hold_valid),
        .load_ready (load_ready),
        .load_data  (core_result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

>>> design/bdlp_chk.sv
// Port-level checker for button_debounce_long_press, attached by bind.
// Depends on bdlp_pkg.

module bdlp_chk
    import bdlp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Input backpressure only when both stages are full and the receiver stalls
    a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input blocked without a stalled result");

    // No event means kind reads as press code
    a_idle_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.event_valid |-> out_data.event_kind == KIND_PRESS)
        else $error("kind set without an event");

    // Event kind is always a defined code
    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.event_valid |->
            out_data.event_kind == KIND_PRESS || out_data.event_kind == KIND_RELEASE
            || out_data.event_kind == KIND_LONG)
        else $error("undefined event kind");

endmodule

bind button_debounce_long_press bdlp_chk u_bdlp_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

>>> verif/tb_button_debounce_long_press.sv
`timescale 1ns / 100ps
// Self-checking testbench for button_debounce_long_press: directed and random sample streams.
// Uses the bdlp_pkg types and constants; needs nothing but the design files.

module tb_button_debounce_long_press;
    import bdlp_pkg::*;

    // Cycles with no transfer on either channel before the run is called hung
    localparam int WATCHDOG_LIMIT = 2000;
    // Pipeline of input and result registers; extra wait for any stray result
    localparam int DRAIN_CYCLES   = 8;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_wen;
    logic        cfg_index;
    logic [15:0] cfg_wdata;

    always #5 clk = ~clk;

    button_debounce_long_press dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Button state mirror: follows every accepted sample and the settings
    // written so far. All state starts cleared, settings at reset values.
    // ------------------------------------------------------------------
    logic        btn_started     = 1'b0;
    logic        btn_last_raw    = 1'b0;
    logic        btn_stable      = 1'b0;
    logic        btn_long_seen   = 1'b0;
    logic [31:0] btn_change_time = '0;
    logic [31:0] btn_press_start = '0;
    logic [15:0] settle_limit    = DEBOUNCE_RESET;
    logic [15:0] hold_limit      = LONG_PRESS_RESET;

    // Events still owed by the block, oldest first
    out_item_t   pending_events[$];

    // Traffic shaping and bookkeeping
    logic        idle_on       = 1'b1;
    int          samples_sent  = 0;
    int          settings_used = 0;
    int          mismatches    = 0;
    int          quiet_cycles  = 0;
    int          press_seen    = 0;
    int          release_seen  = 0;
    int          long_seen     = 0;
    int          silent_seen   = 0;

    // Advance the mirror by one sample and return the event it must cause.
    function automatic out_item_t predict_event(input in_item_t s);
        out_item_t   r;
        logic [31:0] since_change;
        logic [31:0] since_press;
        // Elapsed times wrap modulo 2^32, so backward stamps look huge
        since_change = s.sample_time - btn_change_time;
        since_press  = s.sample_time - btn_press_start;
        r.event_valid  = 1'b0;
        r.event_kind   = KIND_PRESS;
        r.event_action = s.action_tag;
        if (!btn_started)
        begin
            // First sample only loads the state
            btn_started     = 1'b1;
            btn_last_raw    = s.raw_level;
            btn_stable      = s.raw_level;
            btn_long_seen   = 1'b0;
            btn_change_time = s.sample_time;
            btn_press_start = s.raw_level ? s.sample_time : 32'd0;
        end
        else if (s.raw_level != btn_last_raw)
        begin
            // Raw edge: restart the settle timer, no event
            btn_last_raw    = s.raw_level;
            btn_change_time = s.sample_time;
        end
        else if (btn_stable != btn_last_raw && since_change >= 32'(settle_limit))
        begin
            // Settled change wins over the long-press check
            btn_stable = btn_last_raw;
            if (btn_stable)
            begin
                btn_long_seen   = 1'b0;
                btn_press_start = s.sample_time;
                r.event_valid   = 1'b1;
                r.event_kind    = KIND_PRESS;
            end
            else
            begin
                btn_press_start = '0;
                // Release after a reported long press stays quiet
                if (!btn_long_seen)
                begin
                    r.event_valid = 1'b1;
                    r.event_kind  = KIND_RELEASE;
                end
                btn_long_seen = 1'b0;
            end
        end
        else if (hold_limit != 16'd0 && btn_stable && !btn_long_seen &&
                 since_press >= 32'(hold_limit))
        begin
            btn_long_seen = 1'b1;
            r.event_valid = 1'b1;
            r.event_kind  = KIND_LONG;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: check each transfer against the oldest expectation,
    // stall at random, and watch for a hung pipeline.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected result: actual valid=%0b kind=%0d action=%0d",
                         $time, out_data.event_valid, out_data.event_kind,
                         out_data.event_action);
                mismatches++;
            end
            else
            begin
                want = pending_events.pop_front();
                if (out_data.event_valid !== want.event_valid ||
                    out_data.event_kind !== want.event_kind ||
                    out_data.event_action !== want.event_action)
                begin
                    $display("%0t: mismatch: expected valid=%0b kind=%0d action=%0d, %s",
                             $time, want.event_valid, want.event_kind, want.event_action,
                             $sformatf("actual valid=%0b kind=%0d action=%0d",
                                       out_data.event_valid, out_data.event_kind,
                                       out_data.event_action));
                    mismatches++;
                end
                else if (!want.event_valid)
                    silent_seen++;
                else if (want.event_kind == KIND_PRESS)
                    press_seen++;
                else if (want.event_kind == KIND_RELEASE)
                    release_seen++;
                else
                    long_seen++;
            end
        end

        // Stall the result channel on about 8 percent of cycles while idling is on
        out_ready <= !idle_on || ($urandom_range(99) >= 8);

        // Count cycles in which neither channel moves a transfer
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog: no transfer for %0d cycles, %0d events owed",
                     $time, quiet_cycles, pending_events.size());
            $display("FAIL button_debounce_long_press");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sample side helpers
    // ------------------------------------------------------------------

    // Offer one sample; hold valid and payload until the transfer, then
    // record the event it owes. Valid stays high for a following sample.
    task automatic send_sample(input logic raw, input logic [31:0] stamp,
                               input logic [2:0] tag);
        in_item_t s;
        s.raw_level   = raw;
        s.sample_time = stamp;
        s.action_tag  = tag;
        while (idle_on && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_events.push_back(predict_event(s));
        samples_sent++;
    endtask

    // Drop valid and wait until every owed event has come back.
    task automatic drain_results();
        if (in_valid)
            in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
    endtask

    // Write both timing registers on an idle pipeline, one per cycle.
    task automatic set_config(input logic [15:0] db, input logic [15:0] lp);
        drain_results();
        cfg_wen   <= 1'b1;
        cfg_index <= CFG_DEBOUNCE;
        cfg_wdata <= db;
        @(posedge clk);
        cfg_index <= CFG_LONG_PRESS;
        cfg_wdata <= lp;
        @(posedge clk);
        cfg_wen <= 1'b0;
        @(posedge clk);
        settle_limit = db;
        hold_limit   = lp;
        settings_used++;
    endtask

    // Random traffic under one setting. Mostly realistic presses: a short
    // bounce burst, then a hold that may last long enough to settle and to reach
    // the long-press time. The rest is noise: random levels at random
    // stamps, and stamps that step backwards.
    task automatic run_random_phase(input int n_items, input logic [15:0] db,
                                    input logic [15:0] lp);
        int          start_count;
        int          span;
        int          nh;
        int          i;
        int          choice;
        logic        lvl;
        logic [31:0] cursor;
        set_config(db, lp);
        start_count = samples_sent;
        span        = (int'(db) + int'(lp)) / 4 + 1;
        cursor      = $urandom;
        lvl         = 1'($urandom_range(1));
        while (samples_sent - start_count < n_items)
        begin
            choice = $urandom_range(99);
            if (choice < 85)
            begin
                // Bounce at gaps no longer than the debounce time
                repeat ($urandom_range(0, 3))
                begin
                    lvl = !lvl;
                    cursor += $urandom_range(0, db);
                    send_sample(lvl, cursor, 3'($urandom_range(0, 7)));
                end
                // Final edge, then hold the level
                lvl = !lvl;
                cursor += $urandom_range(0, db);
                send_sample(lvl, cursor, 3'($urandom_range(0, 7)));
                nh = $urandom_range(1, 8);
                for (i = 0; i < nh; i++)
                begin
                    // First hold sample often lands right on or just short of the threshold
                    if (i == 0)
                    begin
                        case ($urandom_range(2))
                            0:       cursor += db;
                            1:       cursor += (db == 16'd0) ? 32'd0 : 32'(db) - 32'd1;
                            default: cursor += $urandom_range(0, span);
                        endcase
                    end
                    else
                        cursor += $urandom_range(0, span);
                    send_sample(lvl, cursor, 3'($urandom_range(0, 7)));
                end
            end
            else if (choice < 93)
            begin
                cursor = $urandom;
                lvl    = 1'($urandom_range(1));
                send_sample(lvl, cursor, 3'($urandom_range(0, 7)));
            end
            else
            begin
                cursor -= $urandom_range(1, span);
                lvl     = 1'($urandom_range(1));
                send_sample(lvl, cursor, 3'($urandom_range(0, 7)));
            end
            // Now and then hold the sender until the pipeline empties
            if ($urandom_range(199) == 0)
                drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // First sample pressed near the top of the stamp range; long press
    // one short of and exactly at 800 ms across the wrap; silent release.
    task automatic test_first_sample_and_long_press();
        send_sample(1'b1, 32'hFFFF_FFF0, 3'(samples_sent));
        send_sample(1'b1, 32'h0000_030F, 3'(samples_sent));
        send_sample(1'b1, 32'h0000_0310, 3'(samples_sent));
        send_sample(1'b1, 32'h0000_0320, 3'(samples_sent));
        send_sample(1'b0, 32'h0000_0330, 3'(samples_sent));
        send_sample(1'b0, 32'h0000_0352, 3'(samples_sent));
        send_sample(1'b0, 32'h0000_0353, 3'(samples_sent));
    endtask

    // Bounces restart the timer; press and release settle at exactly 35 ms.
    task automatic test_debounce_threshold();
        send_sample(1'b1, 32'h0000_0400, 3'(samples_sent));
        send_sample(1'b0, 32'h0000_0410, 3'(samples_sent));
        send_sample(1'b1, 32'h0000_0420, 3'(samples_sent));
        send_sample(1'b1, 32'h0000_0443, 3'(samples_sent));
        send_sample(1'b0, 32'h0000_0500, 3'(samples_sent));
        send_sample(1'b0, 32'h0000_0523, 3'(samples_sent));
    endtask

    // Stamps that run backwards look like very long waits.
    task automatic test_backward_time();
        send_sample(1'b1, 32'h0000_0600, 3'(samples_sent));
        send_sample(1'b1, 32'h0000_0100, 3'(samples_sent));
        send_sample(1'b1, 32'h0000_00F0, 3'(samples_sent));
        send_sample(1'b0, 32'hFFFF_FFFF, 3'(samples_sent));
        send_sample(1'b0, 32'h0000_0000, 3'(samples_sent));
        send_sample(1'b0, 32'h0000_0022, 3'(samples_sent));
    endtask

    // Zero debounce with a 1 ms long press, then long press disabled.
    task automatic test_zero_settings();
        set_config(16'd0, 16'd1);
        send_sample(1'b1, 32'h0000_1000, 3'(samples_sent));
        send_sample(1'b1, 32'h0000_1000, 3'(samples_sent));
        send_sample(1'b1, 32'h0000_1000, 3'(samples_sent));
        send_sample(1'b1, 32'h0000_1001, 3'(samples_sent));
        send_sample(1'b0, 32'h0000_1001, 3'(samples_sent));
        send_sample(1'b0, 32'h0000_1001, 3'(samples_sent));
        set_config(16'd0, 16'd0);
        send_sample(1'b1, 32'h0000_2000, 3'(samples_sent));
        send_sample(1'b1, 32'h0000_2000, 3'(samples_sent));
        send_sample(1'b1, 32'h0001_1FFF, 3'(samples_sent));
    endtask

    task automatic test_default_timing();
        run_random_phase(250, DEBOUNCE_RESET, LONG_PRESS_RESET);
    endtask

    task automatic test_extreme_settings();
        run_random_phase(100, 16'd0, 16'd0);
        run_random_phase(100, 16'hFFFF, 16'hFFFF);
        run_random_phase(100, 16'd0, 16'd1);
    endtask

    task automatic test_random_settings();
        repeat (3)
            run_random_phase(100, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    endtask

    // Long stretch with both sides streaming every cycle.
    task automatic test_back_to_back();
        drain_results();
        idle_on = 1'b0;
        run_random_phase(100, 16'd20, 16'd300);
        drain_results();
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_ready <= 1'b0;
        cfg_wen   <= 1'b0;
        cfg_index <= CFG_DEBOUNCE;
        cfg_wdata <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_sample_and_long_press();
        test_debounce_threshold();
        test_backward_time();
        test_zero_settings();
        test_default_timing();
        test_extreme_settings();
        test_random_settings();
        test_back_to_back();

        // Let the pipeline empty, then watch a little longer for strays
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d samples across %0d timing settings, with stalls and back-to-back.",
                 samples_sent, settings_used);
        $display("Checked %0d press, %0d release, %0d long-press and %0d quiet results.",
                 press_seen, release_seen, long_seen, silent_seen);
        if (mismatches == 0 && pending_events.size() == 0)
            $display("PASS button_debounce_long_press");
        else
            $display("FAIL button_debounce_long_press");
        $finish;
    end

endmodule

>>> button_debounce_long_press.f
design/bdlp_pkg.sv
design/bdlp_in_stage.sv
design/bdlp_core.sv
design/bdlp_out_stage.sv
design/button_debounce_long_press.sv
design/bdlp_chk.sv
verif/tb_button_debounce_long_press.sv
